// File: src/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sle assertion failed");

// next-cycle implication, disabled during reset
`define SLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sle assertion failed");

`endif

// File: src/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// shared types and codes of the sequential list engine
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int DATA_W = 32;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DEL_AT = 3'd1;
	localparam logic [2:0] OP_DEL_MIN = 3'd2;
	localparam logic [2:0] OP_DEL_EQ = 3'd3;
	localparam logic [2:0] OP_REVERSE = 3'd4;
	localparam logic [2:0] OP_CHANGE = 3'd5;
	localparam logic [2:0] OP_LOCATE = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [6:0] MAX_LEN_RESET = 7'd64;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_RD2  = 6'b000100,
		S_WR   = 6'b001000,
		S_WR2  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

endpackage

// File: src/sequential_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_top
// ordered list of signed 32-bit words with insert, delete, min, reverse, change, find
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one command item: opcode,
//   position (1-based) and value. the output channel (out_valid/out_ready)
//   returns one result item per command: status, min_value, found_position,
//   removed_count and list_length after the command.
//   the cfg channel writes max_length (low 7 bits of cfg_data); cfg_ready is
//   always high, writes are expected only while the engine is idle.
// work per command (n = element count):
//   every element touched costs one read and one write on the element ram
//   (one write port, one read port). insert shifts n-pos+1 elements, delete at
//   shifts n-pos; delete min scans all n, then shifts; delete equal and locate
//   walk up to n elements; reverse reads and writes both entries of each
//   swapped pair; change and rejected commands go straight to the result.
// in_ready is high only while idle; a finished result waits in the output
// register, and the engine takes the next item meanwhile, stalling only at
// the end of that item's work if the receiver has not taken the last result.
// reset clears the count to zero and max_length to 64; the ram is not cleared,
// entries are always written before they are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sequential_list_engine_top import sle_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data,
	// command items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic [6:0]         position,
	input  logic signed [31:0] value,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] min_value,
	output logic [6:0]         found_position,
	output logic [6:0]         removed_count,
	output logic [6:0]         list_length
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int XW = (CW > 7) ? CW + 1 : 8;

	state_t state_q;

	logic [6:0]        max_length_q;
	logic [CW-1:0]     count_q;
	logic [2:0]        op_q;
	logic [DATA_W-1:0] val_q;
	logic [CW-1:0]     pidx_q;     // validated position - 1
	logic [CW-1:0]     j_q;        // main walk pointer
	logic [CW-1:0]     k_q;        // right pointer / min index
	logic [CW-1:0]     w_q;        // compaction write pointer
	logic              phase_q;    // delete min: 0 scan, 1 shift
	logic [DATA_W-1:0] tmp_q;
	logic [1:0]        st_q;
	logic [DATA_W-1:0] min_q;
	logic [CW-1:0]     found_q;
	logic [CW-1:0]     removed_q;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] min_out_q;
	logic [6:0]        found_out_q;
	logic [6:0]        removed_out_q;
	logic [6:0]        length_out_q;

	// ram ports
	logic              we_c;
	logic [AW-1:0]     waddr_c;
	logic [DATA_W-1:0] wdata_c;
	logic [AW-1:0]     raddr_c;
	logic [DATA_W-1:0] rdata;

	// widened views for range checks
	logic [XW-1:0] pos_x, cnt_x, lim_x, maxl_x;
	logic          ins_ok, at_ok, fin_go, take_min;
	logic [CW:0]   j_w, k_w, cnt_w;

	assign pos_x  = XW'(position);
	assign cnt_x  = XW'(count_q);
	assign maxl_x = XW'(max_length_q);
	assign lim_x  = (maxl_x > XW'(CAPACITY)) ? XW'(CAPACITY) : maxl_x;
	assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
	assign at_ok  = (pos_x != '0) && (pos_x <= cnt_x);

	assign j_w   = {1'b0, j_q};
	assign k_w   = {1'b0, k_q};
	assign cnt_w = {1'b0, count_q};

	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready);
	// first scanned element seeds the minimum; strict less keeps highest position
	assign take_min = (j_q == count_q - CW'(1)) || ($signed(rdata) < $signed(min_q));

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// read address select
	always_comb begin
		raddr_c = j_q[AW-1:0];
		if (state_q == S_RD2) begin
			raddr_c = k_q[AW-1:0];
		end else begin
			case (op_q)
				OP_INSERT: raddr_c = AW'(j_q - CW'(1));
				OP_DEL_AT: raddr_c = AW'(j_q + CW'(1));
				OP_DEL_MIN: raddr_c = phase_q ? AW'(j_q + CW'(1)) : j_q[AW-1:0];
				default: raddr_c = j_q[AW-1:0];
			endcase
		end
	end

	// write port select
	always_comb begin
		we_c    = 1'b0;
		waddr_c = j_q[AW-1:0];
		wdata_c = rdata;
		unique case (state_q)
			S_WR: begin
				case (op_q)
					OP_DEL_MIN: we_c = phase_q;
					OP_DEL_EQ: begin
						we_c    = (rdata != val_q);
						waddr_c = w_q[AW-1:0];
					end
					OP_LOCATE: we_c = 1'b0;
					default: we_c = 1'b1;
				endcase
			end
			S_WR2: begin
				we_c    = 1'b1;
				waddr_c = k_q[AW-1:0];
				wdata_c = tmp_q;
			end
			S_FIN: begin
				we_c    = fin_go && (st_q == ST_OK) &&
					((op_q == OP_INSERT) || (op_q == OP_CHANGE));
				waddr_c = pidx_q[AW-1:0];
				wdata_c = val_q;
			end
			S_IDLE, S_RD, S_RD2: we_c = 1'b0;
			default: we_c = 1'b0;
		endcase
	end

	sle_ram #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(we_c),
		.waddr(waddr_c),
		.wdata(wdata_c),
		.raddr(raddr_c),
		.rdata(rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_length_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= opcode;
						val_q     <= value;
						pidx_q    <= CW'(position - 7'd1);
						phase_q   <= 1'b0;
						st_q      <= ST_OK;
						min_q     <= '0;
						found_q   <= '0;
						removed_q <= '0;
						w_q       <= '0;
						state_q   <= S_FIN;
						case (opcode)
							OP_INSERT: begin
								j_q <= count_q;
								if (!ins_ok) begin
									st_q <= ST_BADPOS;
								end else if (cnt_x >= lim_x) begin
									st_q <= ST_FULL;
								end else if (cnt_x >= pos_x) begin
									state_q <= S_RD;
								end
							end
							OP_DEL_AT: begin
								j_q <= CW'(position - 7'd1);
								if (!at_ok) begin
									st_q <= ST_BADPOS;
								end else if (pos_x < cnt_x) begin
									state_q <= S_RD;
								end
							end
							OP_DEL_MIN: begin
								j_q <= count_q - CW'(1);
								if (count_q == '0) begin
									st_q <= ST_EMPTY;
								end else begin
									state_q <= S_RD;
								end
							end
							OP_DEL_EQ, OP_LOCATE: begin
								j_q <= '0;
								if (count_q != '0) begin
									state_q <= S_RD;
								end
							end
							OP_REVERSE: begin
								j_q <= '0;
								k_q <= count_q - CW'(1);
								if (cnt_x > XW'(1)) begin
									state_q <= S_RD;
								end
							end
							OP_CHANGE: begin
								if (!at_ok) begin
									st_q <= ST_BADPOS;
								end
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					state_q <= (op_q == OP_REVERSE) ? S_RD2 : S_WR;
				end
				S_RD2: begin
					tmp_q   <= rdata;
					state_q <= S_WR;
				end
				S_WR: begin
					state_q <= S_FIN;
					case (op_q)
						OP_INSERT: begin
							j_q <= j_q - CW'(1);
							if (j_q - CW'(1) > pidx_q) begin
								state_q <= S_RD;
							end
						end
						OP_DEL_AT: begin
							j_q <= j_q + CW'(1);
							if (j_w + 2 < cnt_w) begin
								state_q <= S_RD;
							end
						end
						OP_DEL_MIN: begin
							if (phase_q) begin
								j_q <= j_q + CW'(1);
								if (j_w + 2 < cnt_w) begin
									state_q <= S_RD;
								end
							end else begin
								if (take_min) begin
									min_q <= rdata;
									k_q   <= j_q;
								end
								if (j_q == '0) begin
									// scan done, shift out the chosen entry
									phase_q <= 1'b1;
									if (take_min) begin
										j_q <= j_q;
										if (cnt_w > 1) begin
											state_q <= S_RD;
										end
									end else begin
										j_q <= k_q;
										if (k_w + 1 < cnt_w) begin
											state_q <= S_RD;
										end
									end
								end else begin
									j_q     <= j_q - CW'(1);
									state_q <= S_RD;
								end
							end
						end
						OP_DEL_EQ: begin
							if (rdata == val_q) begin
								removed_q <= removed_q + CW'(1);
							end else begin
								w_q <= w_q + CW'(1);
							end
							j_q <= j_q + CW'(1);
							if (j_w + 1 < cnt_w) begin
								state_q <= S_RD;
							end
						end
						OP_REVERSE: begin
							state_q <= S_WR2;
						end
						OP_LOCATE: begin
							if (rdata == val_q) begin
								found_q <= j_q + CW'(1);
							end else begin
								j_q <= j_q + CW'(1);
								if (j_w + 1 < cnt_w) begin
									state_q <= S_RD;
								end
							end
						end
						default: ;
					endcase
				end
				S_WR2: begin
					j_q     <= j_q + CW'(1);
					k_q     <= k_q - CW'(1);
					state_q <= (j_w + 2 < k_w) ? S_RD : S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q       <= S_IDLE;
						out_valid_q   <= 1'b1;
						status_q      <= st_q;
						min_out_q     <= min_q;
						found_out_q   <= 7'(found_q);
						removed_out_q <= 7'(removed_q);
						length_out_q  <= 7'(count_q);
						if (st_q == ST_OK) begin
							case (op_q)
								OP_INSERT: begin
									count_q      <= count_q + CW'(1);
									length_out_q <= 7'(count_q + CW'(1));
								end
								OP_DEL_AT, OP_DEL_MIN: begin
									count_q      <= count_q - CW'(1);
									length_out_q <= 7'(count_q - CW'(1));
								end
								OP_DEL_EQ: begin
									count_q      <= w_q;
									length_out_q <= 7'(w_q);
								end
								default: ;
							endcase
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign min_value      = min_out_q;
	assign found_position = found_out_q;
	assign removed_count  = removed_out_q;
	assign list_length    = length_out_q;

	// count never passes the store depth
	`SLE_ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1, cnt_x <= XW'(CAPACITY))
	// an accepted item keeps the engine busy the next cycle
	`SLE_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// a waiting result reports the current length
	`SLE_ASSERT_IMP(a_len_match, clk, arst_n, out_valid_q, list_length == 7'(count_q))
	// no ram write while idle
	`SLE_ASSERT_IMP(a_idle_no_write, clk, arst_n, state_q == S_IDLE, !we_c)

endmodule

// File: src/sle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ram
// element store: one write port, one registered read port
// ----------------------------------------------------------------------------
module sle_ram import sle_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sim/sequential_list_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_checker
// watches the config, command and result channels, keeps its own copy of the
// list, predicts every result item and compares it field by field
// ----------------------------------------------------------------------------
module sequential_list_engine_checker import sle_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic [6:0]         position,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic signed [31:0] min_value,
	input  logic [6:0]         found_position,
	input  logic [6:0]         removed_count,
	input  logic [6:0]         list_length,
	output int                 fail_count,
	output int                 pending_count,
	output int                 result_count
);

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] min_value;
		logic [6:0]         found_position;
		logic [6:0]         removed_count;
		logic [6:0]         list_length;
	} list_result_t;

	logic signed [31:0] shadow_list [$];
	logic [6:0]         shadow_limit;
	list_result_t       expected_results [$];

	function automatic list_result_t apply_command(logic [2:0] op, logic [6:0] pos,
			logic signed [31:0] val);
		list_result_t r;
		int n;
		int lim;
		int idx;
		int w;
		logic signed [31:0] keep [$];
		r = '0;
		n = shadow_list.size();
		lim = (shadow_limit > CAPACITY) ? CAPACITY : shadow_limit;
		case (op)
			OP_INSERT: begin
				if (pos < 1 || pos > n + 1) r.status = ST_BADPOS;
				else if (n >= lim) r.status = ST_FULL;
				else shadow_list.insert(pos - 1, val);
			end
			OP_DEL_AT: begin
				if (pos < 1 || pos > n) r.status = ST_BADPOS;
				else shadow_list.delete(pos - 1);
			end
			OP_DEL_MIN: begin
				if (n == 0) r.status = ST_EMPTY;
				else begin
					idx = n - 1;
					for (int j = n - 2; j >= 0; j--)
						if (shadow_list[j] < shadow_list[idx]) idx = j;
					r.min_value = shadow_list[idx];
					shadow_list.delete(idx);
				end
			end
			OP_DEL_EQ: begin
				w = 0;
				foreach (shadow_list[j])
					if (shadow_list[j] == val) w++;
					else keep.push_back(shadow_list[j]);
				r.removed_count = w[6:0];
				shadow_list = keep;
			end
			OP_REVERSE: begin
				for (int j = n - 1; j >= 0; j--) keep.push_back(shadow_list[j]);
				shadow_list = keep;
			end
			OP_CHANGE: begin
				if (pos < 1 || pos > n) r.status = ST_BADPOS;
				else shadow_list[pos - 1] = val;
			end
			OP_LOCATE: begin
				for (int j = 0; j < n; j++)
					if (shadow_list[j] == val) begin
						r.found_position = 7'(j + 1);
						break;
					end
			end
			default: ;
		endcase
		r.list_length = 7'(shadow_list.size());
		return r;
	endfunction

	assign pending_count = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		list_result_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			shadow_list.delete();
			expected_results.delete();
			shadow_limit <= MAX_LEN_RESET;
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) shadow_limit <= cfg_data;
			if (in_valid && in_ready)
				expected_results.push_back(apply_command(opcode, position, value));
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (expected_results.size() == 0) begin
					$error("result item with nothing expected");
					errs++;
				end else begin
					e = expected_results.pop_front();
					if (e.status !== status) begin
						$error("status expected %0d actual %0d", e.status, status);
						errs++;
					end
					if (e.min_value !== min_value) begin
						$error("min_value expected %0d actual %0d", e.min_value, min_value);
						errs++;
					end
					if (e.found_position !== found_position) begin
						$error("found_position expected %0d actual %0d",
							e.found_position, found_position);
						errs++;
					end
					if (e.removed_count !== removed_count) begin
						$error("removed_count expected %0d actual %0d",
							e.removed_count, removed_count);
						errs++;
					end
					if (e.list_length !== list_length) begin
						$error("list_length expected %0d actual %0d",
							e.list_length, list_length);
						errs++;
					end
				end
				fail_count <= fail_count + errs;
			end
		end
	end

endmodule

// File: sim/sequential_list_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_top_test
// drives commands and limit writes into the list engine with random gaps and
// back-pressure; the checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
module sequential_list_engine_top_test import sle_pkg::*;;

	localparam int CAPACITY = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 4 * CAPACITY + 20;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [6:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         opcode;
	logic [6:0]         position;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] min_value;
	logic [6:0]         found_position;
	logic [6:0]         removed_count;
	logic [6:0]         list_length;
	int                 fail_count;
	int                 pending_count;
	int                 result_count;

	// tb-side view of the list length, used only to aim positions
	int                 length_guess;
	int                 command_count;
	int                 idle_cycles;
	logic [6:0]         limit_settings [5] = '{7'd1, 7'd127, 7'd0, 7'd5, 7'd64};
	logic signed [31:0] value_pool [4];

	sequential_list_engine_top #(.CAPACITY(CAPACITY)) u_top (.*);

	sequential_list_engine_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// receiver side: random stall between result items, with calm stretches
	initial begin
		int wait_cycles;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// watchdog: cycles where no channel moves an item
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
			$display("sequential_list_engine_top verification failed");
			$finish;
		end
	end

	// one command item, sender gap first; valid stays up when no gap follows
	task automatic send_command(logic [2:0] op, logic [6:0] pos, logic signed [31:0] val,
			bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		position <= pos;
		value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		command_count++;
		length_guess = list_length;
	endtask

	// limit write only once all results are back and the engine has settled
	task automatic write_limit(logic [6:0] lim);
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= lim;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return value_pool[$urandom_range(0, 3)];
			2: return 32'sh8000_0000 + $urandom_range(0, 1);
			default: return $signed($urandom_range(0, 6)) - 3;
		endcase
	endfunction

	// position mostly in range, sometimes just outside, sometimes anywhere
	function automatic logic [6:0] pick_position(int n);
		case ($urandom_range(0, 9))
			0: return 7'($urandom);
			1: return 7'(n + 1 + $urandom_range(0, 1));
			2: return 7'd0;
			default: return 7'($urandom_range(1, n + 1));
		endcase
	endfunction

	initial begin
		logic [2:0] op;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = '0;
		position = '0;
		value = '0;
		command_count = 0;
		length_guess = 0;
		value_pool = '{32'sd7, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list corner cases, then edges of fields
		send_command(OP_DEL_MIN, 7'd0, 32'sd0, 0);
		send_command(OP_DEL_AT, 7'd1, 32'sd0, 0);
		send_command(OP_CHANGE, 7'd1, 32'sd5, 0);
		send_command(OP_DEL_EQ, 7'd0, 32'sd5, 0);
		send_command(OP_REVERSE, 7'd0, 32'sd0, 0);
		send_command(OP_LOCATE, 7'd0, 32'sd0, 0);
		send_command(3'd7, 7'd127, -32'sd1, 0);
		send_command(OP_INSERT, 7'd2, 32'sd1, 0);
		send_command(OP_INSERT, 7'd1, 32'sh7fff_ffff, 0);
		send_command(OP_INSERT, 7'd1, 32'sh8000_0000, 1);
		send_command(OP_INSERT, 7'd3, 32'sh8000_0000, 1);
		send_command(OP_INSERT, 7'd2, -32'sd1, 0);
		send_command(OP_DEL_MIN, 7'd127, -32'sd1, 0);
		send_command(OP_LOCATE, 7'd0, 32'sh7fff_ffff, 0);
		send_command(OP_REVERSE, 7'd0, 32'sd0, 1);
		send_command(OP_CHANGE, 7'd3, 32'sd9, 0);
		send_command(OP_CHANGE, 7'd4, 32'sd9, 0);
		send_command(OP_INSERT, 7'd1, 32'sd9, 0);
		send_command(OP_DEL_EQ, 7'd0, 32'sd9, 0);
		send_command(OP_DEL_AT, 7'd0, 32'sd0, 0);
		send_command(OP_DEL_AT, 7'd2, 32'sd0, 0);

		// a limit of one with one element held: inserts must fail full
		write_limit(7'd1);
		send_command(OP_INSERT, 7'd1, 32'sd3, 0);

		// random phases across several limits, inserts weighted to fill the list
		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) write_limit(limit_settings[phase]);
			for (int k = 0; k < 400; k++) begin
				case ($urandom_range(0, 15))
					0, 1, 2, 3, 4, 5: op = OP_INSERT;
					6, 7: op = OP_DEL_AT;
					8: op = OP_DEL_MIN;
					9: op = OP_DEL_EQ;
					10: op = OP_REVERSE;
					11, 12: op = OP_CHANGE;
					13, 14: op = OP_LOCATE;
					default: op = 3'($urandom);
				endcase
				send_command(op, pick_position(length_guess), pick_value(),
					$urandom_range(0, 4) == 0);
			end
		end

		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d commands and %0d results", command_count, result_count);
		$display("limits swept from zero through values above the store depth");
		if (fail_count == 0)
			$display("sequential_list_engine_top verification clean");
		else
			$display("sequential_list_engine_top verification failed");
		$finish;
	end

endmodule
